/* rtl/tpt_pkg.sv */
package tpt_pkg;

    localparam int PAGE_ENTRIES = 256;
    localparam int TLB_ENTRIES  = 16;
    localparam int OFFSET_W     = 8;

    localparam int ADDR_W    = 16;
    localparam int CNT_W     = 32;
    localparam int PAGE_W    = $clog2(PAGE_ENTRIES);
    localparam int FRAME_W   = $clog2(PAGE_ENTRIES);
    localparam int FCOUNT_W  = FRAME_W + 1;
    localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } t_tlb_lookup;

    typedef struct packed {
        logic               we;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } t_tlb_fill;

endpackage

/* rtl/tpt_page_map.sv */
module tpt_page_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [tpt_pkg::PAGE_W-1:0]  i_rd_page,
    input  logic                        i_wr_en,
    input  logic [tpt_pkg::PAGE_W-1:0]  i_wr_page,
    input  logic [tpt_pkg::FRAME_W-1:0] i_wr_frame,
    output logic [tpt_pkg::FRAME_W-1:0] o_rd_frame,
    output logic                        o_rd_valid
);

    logic [tpt_pkg::FRAME_W-1:0]      r_frames [tpt_pkg::PAGE_ENTRIES];
    logic [tpt_pkg::PAGE_ENTRIES-1:0] r_valid_bits;
    logic [tpt_pkg::FRAME_W-1:0]      r_rd_frame;
    logic                             r_rd_valid;

    // frame storage: synchronous read and write, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_frames[i_wr_page] <= i_wr_frame;
        end
        if (i_rd_en) begin
            r_rd_frame <= r_frames[i_rd_page];
        end
    end

    // mapped flags: cleared at once by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_bits <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid_bits[i_wr_page] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid_bits[i_rd_page];
            end
        end
    end

    assign o_rd_frame = r_rd_frame;
    assign o_rd_valid = r_rd_valid;

endmodule

/* rtl/tpt_tlb.sv */
module tpt_tlb (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tpt_pkg::PAGE_W-1:0] i_page,
    input  tpt_pkg::t_tlb_fill         i_fill,
    output tpt_pkg::t_tlb_lookup       o_lookup
);

    logic [tpt_pkg::PAGE_W-1:0]    r_tags   [tpt_pkg::TLB_ENTRIES];
    logic [tpt_pkg::FRAME_W-1:0]   r_frames [tpt_pkg::TLB_ENTRIES];
    logic [tpt_pkg::TLB_ENTRIES-1:0] r_valid;
    logic [tpt_pkg::TLB_IDX_W-1:0] r_fifo_ptr;
    logic [tpt_pkg::TLB_IDX_W-1:0] n_fifo_ptr;
    logic [tpt_pkg::TLB_ENTRIES-1:0] match;

    // parallel compare against every entry, lowest match wins
    always_comb begin
        o_lookup = '0;
        for (int i = 0; i < tpt_pkg::TLB_ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_tags[i] == i_page);
        end
        for (int i = tpt_pkg::TLB_ENTRIES - 1; i >= 0; i--) begin
            if (match[i]) begin
                o_lookup.hit   = 1'b1;
                o_lookup.frame = r_frames[i];
            end
        end
    end

    always_comb begin
        if (r_fifo_ptr == tpt_pkg::TLB_IDX_W'(tpt_pkg::TLB_ENTRIES - 1)) begin
            n_fifo_ptr = '0;
        end else begin
            n_fifo_ptr = r_fifo_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_fifo_ptr <= '0;
        end else if (i_fill.we) begin
            r_valid[r_fifo_ptr] <= 1'b1;
            r_fifo_ptr          <= n_fifo_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fill.we) begin
            r_tags[r_fifo_ptr]   <= i_fill.page;
            r_frames[r_fifo_ptr] <= i_fill.frame;
        end
    end

endmodule

/* rtl/tlb_page_table_translation.sv */
// An accepted address registers its page, offset and the page map read; in
// ST_LOOKUP the TLB compare resolves the frame and the result is registered to the
// outputs, strobed by o_valid for one cycle. No new address is taken while busy
// (ST_LOOKUP), where the page map result meets the TLB compare and write-back.
// Reset (synchronous, active low) clears TLB and page map valid flags, FIFO
// pointer, frame allocator and counters at once; the receiver cannot stall.
module tlb_page_table_translation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [tpt_pkg::ADDR_W-1:0]    i_virtual_address,
    output logic                          busy,
    output logic                          o_valid,
    output logic [tpt_pkg::ADDR_W-1:0]    o_phys_addr,
    output logic                          o_tlb_hit,
    output logic                          o_page_fault,
    output logic [tpt_pkg::CNT_W-1:0]     o_translated_count,
    output logic [tpt_pkg::CNT_W-1:0]     o_hit_count,
    output logic [tpt_pkg::FCOUNT_W-1:0]  o_fault_count
);

    tpt_pkg::t_state                r_state;
    tpt_pkg::t_state                n_state;
    logic [tpt_pkg::PAGE_W-1:0]     r_page;
    logic [tpt_pkg::OFFSET_W-1:0]   r_offset;
    logic [tpt_pkg::FCOUNT_W-1:0]   r_next_frame;
    logic [tpt_pkg::FCOUNT_W-1:0]   n_next_frame;
    logic [tpt_pkg::CNT_W-1:0]      r_total;
    logic [tpt_pkg::CNT_W-1:0]      n_total;
    logic [tpt_pkg::CNT_W-1:0]      r_hits;
    logic [tpt_pkg::CNT_W-1:0]      n_hits;
    logic                           r_valid;
    logic [tpt_pkg::ADDR_W-1:0]     r_pa;
    logic                           r_hit;
    logic                           r_fault;

    logic                           accept;
    logic                           lookup;
    logic                           fault;
    logic [tpt_pkg::FRAME_W-1:0]    frame;
    logic [tpt_pkg::FRAME_W+tpt_pkg::OFFSET_W-1:0] pa_full;
    logic [tpt_pkg::FRAME_W-1:0]    pm_frame;
    logic                           pm_valid;
    tpt_pkg::t_tlb_lookup           tlb_res;
    tpt_pkg::t_tlb_fill             tlb_fill;

    tpt_page_map u_page_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_page  (i_virtual_address[tpt_pkg::OFFSET_W +: tpt_pkg::PAGE_W]),
        .i_wr_en    (fault),
        .i_wr_page  (r_page),
        .i_wr_frame (frame),
        .o_rd_frame (pm_frame),
        .o_rd_valid (pm_valid)
    );

    tpt_tlb u_tlb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_page   (r_page),
        .i_fill   (tlb_fill),
        .o_lookup (tlb_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tpt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        accept  = 1'b0;
        lookup  = 1'b0;
        unique case (r_state)
            tpt_pkg::ST_IDLE: begin
                accept = start;
                if (start) begin
                    n_state = tpt_pkg::ST_LOOKUP;
                end
            end
            tpt_pkg::ST_LOOKUP: begin
                busy    = 1'b1;
                lookup  = 1'b1;
                n_state = tpt_pkg::ST_IDLE;
            end
            default: begin
                n_state = tpt_pkg::ST_IDLE;
            end
        endcase
    end

    // resolve the frame: TLB first, then page map, else allocate
    always_comb begin
        fault = 1'b0;
        if (tlb_res.hit) begin
            frame = tlb_res.frame;
        end else if (pm_valid) begin
            frame = pm_frame;
        end else begin
            frame = r_next_frame[tpt_pkg::FRAME_W-1:0];
            fault = lookup;
        end

        tlb_fill.we    = lookup && !tlb_res.hit;
        tlb_fill.page  = r_page;
        tlb_fill.frame = frame;

        pa_full = {frame, r_offset};

        n_next_frame = r_next_frame;
        if (fault && (r_next_frame != tpt_pkg::FCOUNT_W'(tpt_pkg::PAGE_ENTRIES))) begin
            n_next_frame = r_next_frame + 1'b1;
        end

        // saturate the running counts
        n_total = (r_total == '1) ? r_total : r_total + 1'b1;
        n_hits  = r_hits;
        if (tlb_res.hit && (r_hits != '1)) begin
            n_hits = r_hits + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_frame <= '0;
            r_total      <= '0;
            r_hits       <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= lookup;
            if (lookup) begin
                r_next_frame <= n_next_frame;
                r_total      <= n_total;
                r_hits       <= n_hits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_page   <= i_virtual_address[tpt_pkg::OFFSET_W +: tpt_pkg::PAGE_W];
            r_offset <= i_virtual_address[tpt_pkg::OFFSET_W-1:0];
        end
        if (lookup) begin
            r_pa    <= pa_full[tpt_pkg::ADDR_W-1:0];
            r_hit   <= tlb_res.hit;
            r_fault <= fault;
        end
    end

    assign o_valid            = r_valid;
    assign o_phys_addr        = r_pa;
    assign o_tlb_hit          = r_hit;
    assign o_page_fault       = r_fault;
    assign o_translated_count = r_total;
    assign o_hit_count        = r_hits;
    assign o_fault_count      = r_next_frame;

`ifndef SYNTH
    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not enter lookup");

    a_lookup_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_valid))
        else $error("lookup did not finish in one cycle with a result");

    a_valid_after_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without a lookup");

    a_fault_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_page_fault) |-> (!o_tlb_hit && o_fault_count != '0))
        else $error("page fault flagged on a TLB hit or with zero fault count");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import tpt_pkg::*;

    localparam int GAP_MAX       = 5;
    localparam int RANDOM_ITEMS  = 376;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int REPORT_LIMIT  = 10;
    localparam int RECENT_DEPTH  = 8;

    typedef struct packed {
        logic [ADDR_W-1:0]   phys;
        logic                hit;
        logic                fault;
        logic [CNT_W-1:0]    xlat_total;
        logic [CNT_W-1:0]    hit_total;
        logic [FCOUNT_W-1:0] frames_used;
    } t_xlat_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [ADDR_W-1:0]    i_virtual_address = '0;
    logic                 busy;
    logic                 o_valid;
    logic [ADDR_W-1:0]    o_phys_addr;
    logic                 o_tlb_hit;
    logic                 o_page_fault;
    logic [CNT_W-1:0]     o_translated_count;
    logic [CNT_W-1:0]     o_hit_count;
    logic [FCOUNT_W-1:0]  o_fault_count;

    // translation state tracked by the testbench
    logic                 map_valid [PAGE_ENTRIES] = '{default: 1'b0};
    logic [FRAME_W-1:0]   map_frame [PAGE_ENTRIES] = '{default: '0};
    logic                 tlb_valid [TLB_ENTRIES] = '{default: 1'b0};
    logic [PAGE_W-1:0]    tlb_tag_pg [TLB_ENTRIES] = '{default: '0};
    logic [FRAME_W-1:0]   tlb_frame [TLB_ENTRIES] = '{default: '0};
    logic [TLB_IDX_W-1:0] fifo_ptr = '0;
    logic [FCOUNT_W-1:0]  next_frame = '0;
    logic [CNT_W-1:0]     xlat_total = '0;
    logic [CNT_W-1:0]     hit_total = '0;

    logic [ADDR_W-1:0]    pending_addrs [$];
    t_xlat_result         expected_xlats [$];
    int                   n_mismatches = 0;
    int                   hold_cycles = 0;
    bit                   steady = 1'b0;
    int                   stall_cycles = 0;

    // stimulus-side bookkeeping
    bit                   touched [PAGE_ENTRIES] = '{default: 1'b0};
    logic [PAGE_W-1:0]    recent_pages [$];

    tlb_page_table_translation dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .i_virtual_address  (i_virtual_address),
        .busy               (busy),
        .o_valid            (o_valid),
        .o_phys_addr        (o_phys_addr),
        .o_tlb_hit          (o_tlb_hit),
        .o_page_fault       (o_page_fault),
        .o_translated_count (o_translated_count),
        .o_hit_count        (o_hit_count),
        .o_fault_count      (o_fault_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_xlat_result translate(input logic [ADDR_W-1:0] va);
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
        logic               hit;
        logic               fault;
        t_xlat_result       r;
        page  = va[OFFSET_W +: PAGE_W];
        frame = '0;
        hit   = 1'b0;
        fault = 1'b0;
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && tlb_valid[i] && tlb_tag_pg[i] == page) begin
                hit   = 1'b1;
                frame = tlb_frame[i];
            end
        end
        if (!hit) begin
            if (!map_valid[page]) begin
                // allocate frames in order, saturating at the table size
                fault           = 1'b1;
                frame           = next_frame[FRAME_W-1:0];
                map_valid[page] = 1'b1;
                map_frame[page] = frame;
                if (next_frame < PAGE_ENTRIES)
                    next_frame++;
            end else begin
                frame = map_frame[page];
            end
            tlb_valid[fifo_ptr]  = 1'b1;
            tlb_tag_pg[fifo_ptr] = page;
            tlb_frame[fifo_ptr]  = frame;
            fifo_ptr++;
        end else if (hit_total != '1) begin
            hit_total++;
        end
        if (xlat_total != '1)
            xlat_total++;
        r.phys        = {frame, va[OFFSET_W-1:0]};
        r.hit         = hit;
        r.fault       = fault;
        r.xlat_total  = xlat_total;
        r.hit_total   = hit_total;
        r.frames_used = next_frame;
        return r;
    endfunction

    function automatic int draw_gap();
        // alternate between stretches of back-to-back traffic and random gaps
        if ($urandom_range(0, 19) == 0)
            steady = !steady;
        return steady ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic queue_address(input logic [ADDR_W-1:0] va);
        logic [PAGE_W-1:0] page;
        page = va[OFFSET_W +: PAGE_W];
        pending_addrs.push_back(va);
        touched[page] = 1'b1;
        recent_pages.push_back(page);
        if (recent_pages.size() > RECENT_DEPTH)
            void'(recent_pages.pop_front());
    endtask

    function automatic int find_page(input bit want_touched);
        int base;
        base = $urandom_range(0, PAGE_ENTRIES - 1);
        for (int i = 0; i < PAGE_ENTRIES; i++) begin
            if (touched[(base + i) % PAGE_ENTRIES] == want_touched)
                return (base + i) % PAGE_ENTRIES;
        end
        return -1;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (want !== got) begin
            n_mismatches++;
            if (n_mismatches <= REPORT_LIMIT)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start       <= 1'b0;
            hold_cycles = draw_gap();
        end else begin
            if (start && !busy)
                expected_xlats.push_back(translate(i_virtual_address));
            if (!start || !busy) begin
                if (hold_cycles > 0) begin
                    start <= 1'b0;
                    hold_cycles--;
                end else if (pending_addrs.size() > 0) begin
                    start             <= 1'b1;
                    i_virtual_address <= pending_addrs.pop_front();
                    hold_cycles       = draw_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_xlat_result want;
        if (i_rst_n && o_valid) begin
            if (expected_xlats.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= REPORT_LIMIT)
                    $display("unexpected transaction: phys 0x%0h", o_phys_addr);
            end else begin
                want = expected_xlats.pop_front();
                check_field("phys_addr", want.phys, o_phys_addr);
                check_field("tlb_hit", want.hit, o_tlb_hit);
                check_field("page_fault", want.fault, o_page_fault);
                check_field("translated_count", want.xlat_total, o_translated_count);
                check_field("hit_count", want.hit_total, o_hit_count);
                check_field("fault_count", want.frames_used, o_fault_count);
            end
        end
    end

    // watchdog: abort when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int                pick;
        int                page;
        logic [OFFSET_W-1:0] offset;

        // offset extremes, first fault, TLB hit on the same page
        queue_address(16'h0000);
        queue_address(16'h00FF);
        queue_address(16'hFFFF);
        queue_address(16'hFF00);
        // fill past TLB capacity so FIFO replacement wraps and evicts pages 0 and 255
        for (int p = 1; p <= 16; p++)
            queue_address({p[PAGE_W-1:0], p[OFFSET_W-1:0] ^ 8'hA5});
        // pages 0 and 255, evicted but mapped, hit the page table with no fault; AA and 55 then fault
        queue_address(16'h0012);
        queue_address(16'hFF34);
        queue_address(16'hAA55);
        queue_address(16'h55AA);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick   = $urandom_range(0, 99);
            offset = OFFSET_W'($urandom_range(0, (1 << OFFSET_W) - 1));
            page   = -1;
            if (pick < 60)
                page = find_page(1'b0);
            else if (pick < 80)
                page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
            else if (pick < 92)
                page = find_page(1'b1);
            if (page < 0)
                page = $urandom_range(0, PAGE_ENTRIES - 1);
            queue_address({page[PAGE_W-1:0], offset});
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_addrs.size() != 0 || start || expected_xlats.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tpt_pkg.sv
rtl/tpt_page_map.sv
rtl/tpt_tlb.sv
rtl/tlb_page_table_translation.sv
tb/tb.sv
